[rtl/core/lckp_pkg.sv]
package lckp_pkg;

    localparam int LINE_CAPACITY = 32;
    localparam int LINE_DEPTH    = LINE_CAPACITY - 1;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);
    localparam int ADDR_W        = $clog2(LINE_DEPTH);

    localparam int KW_COUNT = 20;
    localparam int KW_MAX   = 16;
    localparam int KW_BITS  = 8 * KW_MAX;
    localparam int CODE_W   = 5;

    localparam logic [CODE_W-1:0] CODE_NONE    = CODE_W'(0);
    localparam logic [CODE_W-1:0] CODE_UNKNOWN = CODE_W'(21);

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_READY   = 2'd1,
        ST_ERROR   = 2'd2
    } t_status;

    // Control from the sequencer to the keyword matcher.
    typedef struct packed {
        logic              init;
        logic              step;
        logic [ADDR_W-1:0] idx;
        logic [7:0]        ch;
    } t_match_ctl;

    // Keyword text, right-justified, first character in the highest used byte.
    function automatic logic [KW_BITS-1:0] kw_str(input int k);
        case (k)
            0:       return KW_BITS'("status");
            1:       return KW_BITS'("disable-all");
            2:       return KW_BITS'("read-raw");
            3:       return KW_BITS'("capture-stand");
            4:       return KW_BITS'("capture-crouch");
            5:       return KW_BITS'("capture-extend");
            6:       return KW_BITS'("select-a");
            7:       return KW_BITS'("select-b");
            8:       return KW_BITS'("select-wheel");
            9:       return KW_BITS'("arm");
            10:      return KW_BITS'("jog-positive");
            11:      return KW_BITS'("jog-negative");
            12:      return KW_BITS'("stop-all");
            13:      return KW_BITS'("power-arm");
            14:      return KW_BITS'("power-on");
            15:      return KW_BITS'("probe");
            16:      return KW_BITS'("phase10-arm");
            17:      return KW_BITS'("move-stand");
            18:      return KW_BITS'("move-mid-crouch");
            19:      return KW_BITS'("move-mid-extend");
            default: return '0;
        endcase
    endfunction

    function automatic int kw_len(input int k);
        logic [KW_BITS-1:0] s;
        int n;
        s = kw_str(k);
        n = 0;
        for (int b = 0; b < KW_MAX; b++) begin
            if (s[8*b +: 8] != 8'h00) begin
                n = n + 1;
            end
        end
        return n;
    endfunction

    function automatic logic [7:0] kw_char(input int k, input int i);
        logic [KW_BITS-1:0] s;
        int n;
        s = kw_str(k);
        n = kw_len(k);
        if (i < n) begin
            return s[8*(n-1-i) +: 8];
        end
        return 8'h00;
    endfunction

endpackage

[rtl/core/line_command_keyword_parser.sv]
// Line command parser: takes one received byte per transaction and returns one
// status/code result per byte. Letters, digits and '-' are stored (upper case
// folded to lower) in a 31-entry line RAM; CR or LF ends the line. An
// ordinary byte's result passes through a hold register to the output
// register. For a CR or LF ending a non-empty line, the stored line is first
// read back from the RAM one character per cycle while all twenty keywords are
// compared in parallel against that character. A new byte is taken while the
// previous result still waits on the output, one result deep.
module line_command_keyword_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_parse_status,
    output logic [4:0] o_command_code
);

    localparam int LEN_W  = lckp_pkg::LEN_W;
    localparam int ADDR_W = lckp_pkg::ADDR_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                      r_state;
    logic [LEN_W-1:0]            r_len;
    logic                        r_ovf;
    logic [LEN_W-1:0]            r_rd_idx;
    logic                        r_cv;
    logic [ADDR_W-1:0]           r_ci;
    logic                        r_hold_valid;
    lckp_pkg::t_status           r_hold_status;
    logic [lckp_pkg::CODE_W-1:0] r_hold_code;
    logic                        r_out_valid;
    lckp_pkg::t_status           r_out_status;
    logic [lckp_pkg::CODE_W-1:0] r_out_code;

    logic                        accept;
    logic                        is_eol;
    logic [7:0]                  lc;
    logic                        legal;
    logic                        full;
    logic                        ram_we;
    logic                        rd_go;
    logic                        last_char;
    logic                        out_load;
    logic [7:0]                  ram_rdata;
    logic [lckp_pkg::CODE_W-1:0] match_code;
    lckp_pkg::t_match_ctl        mctl;

    assign o_ready  = (r_state == S_IDLE) && !r_hold_valid;
    assign accept   = i_valid && o_ready;
    assign out_load = r_hold_valid && (!r_out_valid || i_ready);

    always_comb begin
        is_eol = (i_rx_byte == lckp_pkg::CH_CR) || (i_rx_byte == lckp_pkg::CH_LF);
        if (i_rx_byte >= lckp_pkg::CH_UPPER_A && i_rx_byte <= lckp_pkg::CH_UPPER_Z) begin
            lc = i_rx_byte + lckp_pkg::CASE_OFFSET;
        end else begin
            lc = i_rx_byte;
        end
        legal = (lc >= lckp_pkg::CH_LOWER_A && lc <= lckp_pkg::CH_LOWER_Z) ||
                (lc >= lckp_pkg::CH_DIGIT_0 && lc <= lckp_pkg::CH_DIGIT_9) ||
                (lc == lckp_pkg::CH_DASH);
        full      = (r_len >= LEN_W'(lckp_pkg::LINE_CAPACITY - 1));
        ram_we    = accept && !is_eol && legal && !full && !r_ovf;
        rd_go     = (r_state == S_SCAN) && (r_rd_idx != r_len);
        last_char = (LEN_W'(r_ci) == r_len - LEN_W'(1));

        mctl.init = accept && is_eol && !r_ovf && (r_len != '0);
        mctl.step = (r_state == S_SCAN) && r_cv;
        mctl.idx  = r_ci;
        mctl.ch   = ram_rdata;
    end

    lckp_ram #(
        .WIDTH (8),
        .DEPTH (lckp_pkg::LINE_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_len[ADDR_W-1:0]),
        .i_wdata (lc),
        .i_re    (rd_go),
        .i_raddr (r_rd_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    lckp_match u_match (
        .i_clk      (i_clk),
        .i_ctl      (mctl),
        .i_line_len (r_len),
        .o_code     (match_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_len        <= '0;
            r_ovf        <= 1'b0;
            r_rd_idx     <= '0;
            r_cv         <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_hold_status;
                r_out_code   <= r_hold_code;
                r_hold_valid <= 1'b0;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_hold_code <= lckp_pkg::CODE_NONE;
                        if (is_eol) begin
                            if (r_ovf) begin
                                r_hold_valid  <= 1'b1;
                                r_hold_status <= lckp_pkg::ST_ERROR;
                                r_len         <= '0;
                                r_ovf         <= 1'b0;
                            end else if (r_len != '0) begin
                                r_rd_idx <= '0;
                                r_cv     <= 1'b0;
                                r_state  <= S_SCAN;
                            end else begin
                                r_hold_valid  <= 1'b1;
                                r_hold_status <= lckp_pkg::ST_PENDING;
                            end
                        end else if (!legal) begin
                            r_hold_valid  <= 1'b1;
                            r_hold_status <= lckp_pkg::ST_ERROR;
                            r_len         <= '0;
                            r_ovf         <= 1'b0;
                        end else begin
                            r_hold_valid  <= 1'b1;
                            r_hold_status <= lckp_pkg::ST_PENDING;
                            if (full) begin
                                r_ovf <= 1'b1;
                            end else if (!r_ovf) begin
                                r_len <= r_len + LEN_W'(1);
                            end
                        end
                    end
                end
                S_SCAN: begin
                    // Reads are issued back to back; r_cv and r_ci track the
                    // character that the RAM returns in the following cycle.
                    if (rd_go) begin
                        r_rd_idx <= r_rd_idx + LEN_W'(1);
                        r_cv     <= 1'b1;
                        r_ci     <= r_rd_idx[ADDR_W-1:0];
                    end else begin
                        r_cv <= 1'b0;
                    end
                    if (r_cv && last_char) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_hold_valid  <= 1'b1;
                    r_hold_code   <= match_code;
                    r_hold_status <= (match_code == lckp_pkg::CODE_UNKNOWN) ?
                                     lckp_pkg::ST_ERROR : lckp_pkg::ST_READY;
                    r_len         <= '0;
                    r_ovf         <= 1'b0;
                    r_state       <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_parse_status = r_out_status;
    assign o_command_code = r_out_code;

`ifndef SYNTHESIS
    a_ovf_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_len == LEN_W'(lckp_pkg::LINE_CAPACITY - 1)))
        else $error("overflow flag set with buffer not full");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((r_len != '0) && !r_ovf))
        else $error("keyword scan on an empty or overflowed line");

    a_done_hold_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !r_hold_valid)
        else $error("match result would overwrite a pending result");

    a_eol_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mctl.init |=> (r_state == S_SCAN) && (r_rd_idx == '0))
        else $error("end of line did not start the line readback");
`endif

endmodule

[rtl/core/lckp_ram.sv]
module lckp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/lckp_match.sv]
module lckp_match (
    input  logic                       i_clk,
    input  lckp_pkg::t_match_ctl       i_ctl,
    input  logic [lckp_pkg::LEN_W-1:0] i_line_len,
    output logic [lckp_pkg::CODE_W-1:0] o_code
);

    logic [lckp_pkg::KW_COUNT-1:0] r_cand;
    logic [lckp_pkg::KW_COUNT-1:0] n_cand;

    // Each keyword stays a candidate while its length equals the line length and every
    // character read back so far agrees with it.
    always_comb begin
        n_cand = r_cand;
        if (i_ctl.init) begin
            for (int k = 0; k < lckp_pkg::KW_COUNT; k++) begin
                n_cand[k] = (lckp_pkg::kw_len(k) == int'(i_line_len));
            end
        end else if (i_ctl.step) begin
            for (int k = 0; k < lckp_pkg::KW_COUNT; k++) begin
                n_cand[k] = r_cand[k] &&
                            (lckp_pkg::kw_char(k, int'(i_ctl.idx)) == i_ctl.ch);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
    end

    always_comb begin
        o_code = lckp_pkg::CODE_UNKNOWN;
        for (int k = lckp_pkg::KW_COUNT - 1; k >= 0; k--) begin
            if (r_cand[k]) begin
                o_code = lckp_pkg::CODE_W'(k + 1);
            end
        end
    end

endmodule
